FILE: design/pfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfp_pkg
// Shared constants and types for the position frame parser.
// ----------------------------------------------------------------------------
package pfp_pkg;

   // Payload length of one frame in bytes (4 to 64)
   localparam int PAYLOAD_BYTES = 24;

   // Words emitted per frame: whole words of payload, capped at six
   localparam int RAW_WORDS  = PAYLOAD_BYTES / 4;
   localparam int WORD_COUNT = (RAW_WORDS < 6) ? RAW_WORDS : 6;

   localparam int CNT_W   = $clog2(PAYLOAD_BYTES);
   localparam int INDEX_W = 3;
   localparam int WORD_W  = 32;

   // Frame delimiters
   localparam logic [7:0] HDR_FIRST  = 8'h0D;
   localparam logic [7:0] HDR_SECOND = 8'h0A;
   localparam logic [7:0] TRL_FIRST  = 8'h0A;
   localparam logic [7:0] TRL_SECOND = 8'h0D;

   // Control from the sequencer to the byte cells
   typedef struct packed {
      logic capture;   // shift one byte in at the tail
      logic drain;     // advance four bytes toward the head
   } ctl_type;

endpackage

FILE: design/pfp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfp_req_if / pfp_rsp_if
// Valid/ready channels for received bytes and payload words.
// ----------------------------------------------------------------------------
interface pfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface pfp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  word_index;
   logic [31:0] word_value;
   logic        last;

   modport source (output valid, output word_index, output word_value, output last,
                   input ready);
   modport sink   (input valid, input word_index, input word_value, input last,
                   output ready);
endinterface

FILE: design/position_frame_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// position_frame_parser_top
// Byte-serial frame sync; emits payload as little-endian 32-bit words.
// ----------------------------------------------------------------------------
// Usage:
//  - req_chan carries one received byte per transaction. Frames are
//    0x0D 0x0A, PAYLOAD_BYTES payload bytes, 0x0A 0x0D. A repeated 0x0D
//    while waiting for 0x0A keeps waiting; any other bad delimiter drops
//    back to hunting and nothing is emitted for that frame.
//  - Bytes are accepted one per cycle while req ready is high; header,
//    payload and trailer bytes can arrive back to back.
//  - On the closing 0x0D the block drains WORD_COUNT words on rsp_chan,
//    the first visible the cycle after that byte is accepted, then one per
//    cycle while rsp ready stays high. word_index counts from 0; last marks
//    the final word.
//  - Payload sits in a chain of byte cells: each payload byte enters at the
//    tail and shifts one cell on; each delivered word moves the chain four
//    cells toward the head, so the head always holds the next word.
//  - While words drain, req ready is low: no byte is accepted until the
//    last word of the frame is taken, including through any rsp stall.
//  - A stalled receiver holds the current word stable; nothing is lost.
//  - Synchronous reset returns to hunting with no words pending. Cell
//    contents are not cleared; every cell is rewritten before any frame
//    completes.
// ----------------------------------------------------------------------------
module position_frame_parser_top
   import pfp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   pfp_req_if.sink         req_chan,
   pfp_rsp_if.source       rsp_chan
);

   ctl_type    ctl;
   logic [7:0] cell_q [PAYLOAD_BYTES];

   pfp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_byte  (req_chan.rx_byte),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .rsp_index (rsp_chan.word_index),
      .rsp_last  (rsp_chan.last),
      .ctl       (ctl)
   );

   // Cell 0 is the head (oldest byte); new bytes enter at the tail.
   for (genvar i = 0; i < PAYLOAD_BYTES; i++) begin : g_cell
      logic [7:0] step_src;
      logic [7:0] jump_src;

      if (i == PAYLOAD_BYTES - 1) begin : g_tail
         assign step_src = req_chan.rx_byte;
      end else begin : g_body
         assign step_src = cell_q[i + 1];
      end

      if (i + 4 < PAYLOAD_BYTES) begin : g_jump
         assign jump_src = cell_q[i + 4];
      end else begin : g_nojump
         assign jump_src = 8'h00;
      end

      pfp_cell u_cell (
         .clock   (clock),
         .ctl     (ctl),
         .step_in (step_src),
         .jump_in (jump_src),
         .data_ff (cell_q[i])
      );
   end

   // Head four cells form the current word, lowest address in the low byte.
   assign rsp_chan.word_value = {cell_q[3], cell_q[2], cell_q[1], cell_q[0]};

endmodule

FILE: design/pfp_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfp_cell
// One payload byte cell; loads from the next cell or from four cells on.
// ----------------------------------------------------------------------------
module pfp_cell
   import pfp_pkg::*;
(
   input  logic       clock,
   input  ctl_type    ctl,
   input  logic [7:0] step_in,   // neighbor one place toward the tail
   input  logic [7:0] jump_in,   // cell four places toward the tail
   output logic [7:0] data_ff
);

   logic [7:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (ctl.capture) begin
         data_in = step_in;
      end else if (ctl.drain) begin
         data_in = jump_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

FILE: design/pfp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfp_ctrl
// Frame sync sequencer: header/trailer phases, byte count, word drain.
// ----------------------------------------------------------------------------
module pfp_ctrl
   import pfp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic [7:0]         req_byte,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [INDEX_W-1:0] rsp_index,
   output logic               rsp_last,
   output ctl_type            ctl
);

   localparam logic [2:0] PH_HUNT    = 3'd0;
   localparam logic [2:0] PH_HDR2    = 3'd1;
   localparam logic [2:0] PH_COLLECT = 3'd2;
   localparam logic [2:0] PH_TRL1    = 3'd3;
   localparam logic [2:0] PH_TRL2    = 3'd4;

   localparam logic [CNT_W-1:0]   CNT_LAST  = CNT_W'(PAYLOAD_BYTES - 1);
   localparam logic [INDEX_W-1:0] INDEX_LAST = INDEX_W'(WORD_COUNT - 1);

   logic [2:0]         phase_ff, phase_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               drain_ff, drain_in;
   logic [INDEX_W-1:0] index_ff, index_in;
   logic               req_fire;
   logic               rsp_fire;

   assign req_ready = !drain_ff;
   assign rsp_valid = drain_ff;
   assign rsp_index = index_ff;
   assign rsp_last  = (index_ff == INDEX_LAST);
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = drain_ff && rsp_ready;

   always_comb begin
      phase_in    = phase_ff;
      count_in    = count_ff;
      drain_in    = drain_ff;
      index_in    = index_ff;
      ctl.capture = 1'b0;
      ctl.drain   = rsp_fire;

      if (rsp_fire) begin
         if (rsp_last) begin
            drain_in = 1'b0;
         end else begin
            index_in = index_ff + INDEX_W'(1);
         end
      end

      if (req_fire) begin
         unique case (phase_ff)
            PH_HUNT: begin
               phase_in = (req_byte == HDR_FIRST) ? PH_HDR2 : PH_HUNT;
            end
            PH_HDR2: begin
               if (req_byte == HDR_SECOND) begin
                  count_in = '0;
                  phase_in = PH_COLLECT;
               end else if (req_byte != HDR_FIRST) begin
                  phase_in = PH_HUNT;
               end
            end
            PH_COLLECT: begin
               ctl.capture = 1'b1;
               if (count_ff == CNT_LAST) begin
                  count_in = '0;
                  phase_in = PH_TRL1;
               end else begin
                  count_in = count_ff + CNT_W'(1);
               end
            end
            PH_TRL1: begin
               phase_in = (req_byte == TRL_FIRST) ? PH_TRL2 : PH_HUNT;
            end
            PH_TRL2: begin
               if (req_byte == TRL_SECOND) begin
                  drain_in = 1'b1;
                  index_in = '0;
               end
               phase_in = PH_HUNT;
            end
            default: begin
               phase_in = PH_HUNT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         count_ff <= '0;
         drain_ff <= 1'b0;
         index_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         drain_ff <= drain_in;
         index_ff <= index_in;
      end
   end

   // Assertions
   a_capture_in_collect: assert property (@(posedge clock) disable iff (reset)
      ctl.capture |-> (phase_ff == PH_COLLECT))
      else $error("byte captured outside payload phase");

   a_drain_from_trailer: assert property (@(posedge clock) disable iff (reset)
      $rose(drain_ff) |-> ($past(phase_ff) == PH_TRL2))
      else $error("drain started without closing trailer");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      drain_ff |-> (index_ff <= INDEX_LAST))
      else $error("word index past last word");

   a_last_ends_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_last) |=> !drain_ff)
      else $error("drain continued past last word");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      ctl.capture |-> !ctl.drain)
      else $error("capture and drain in one cycle");

endmodule
